FILE: rtl/sorted_priority_queue_assert.svh
// assertion macros for the sorted priority queue
// used by rtl files that check their own logic; needs clock and reset in scope
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define SPQ_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("spq assertion failed");
// next-cycle implication
`define SPQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("spq assertion failed");
`else
`define SPQ_ASSERT_NOW(label, ante, cons)
`define SPQ_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: rtl/spq_pkg.sv
// shared types and constants of the sorted priority queue
// no dependencies
`default_nettype none

package spq_pkg;

   localparam int CAPACITY = 32;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   typedef logic signed [31:0] value_type;
   typedef logic [CNT_W-1:0]   count_type;

   typedef enum logic [1:0] {
      ACT_INSERT  = 2'd0,
      ACT_REMOVE  = 2'd1,
      ACT_DISPLAY = 2'd2
   } action_type;

   typedef enum logic [2:0] {
      ST_INSERTED  = 3'd0,
      ST_REMOVED   = 3'd1,
      ST_OVERFLOW  = 3'd2,
      ST_UNDERFLOW = 3'd3,
      ST_EMPTY     = 3'd4,
      ST_SHOWN     = 3'd5
   } status_type;

   // operation broadcast to every cell of the chain
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_SHIFT,
      CELL_ROTATE
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      value_type   key;
      count_type   count;
      count_type   last_idx;
   } cell_ctrl_type;

endpackage

`default_nettype wire

FILE: rtl/spq_if.sv
// request and response channel interfaces of the sorted priority queue
// depends on spq_pkg
`default_nettype none

interface spq_req_if import spq_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [1:0] action;
   value_type  value;

   modport source (output valid, output action, output value, input ready);
   modport sink   (input valid, input action, input value, output ready);
endinterface

interface spq_rsp_if import spq_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [2:0] status;
   value_type  item_value;
   logic       last;

   modport source (output valid, output status, output item_value, output last,
                   input ready);
   modport sink   (input valid, input status, input item_value, input last,
                   output ready);
endinterface

`default_nettype wire

FILE: rtl/spq_cell.sv
// one slot of the sorted chain: holds a value, trades with its neighbours
// depends on spq_pkg
`default_nettype none

module spq_cell import spq_pkg::*; (
   input  wire logic          clock,
   input  wire count_type     cell_index,
   input  wire cell_ctrl_type ctrl,
   input  wire value_type     left_value,
   input  wire logic          left_greater,
   input  wire value_type     right_value,
   input  wire value_type     head_value,
   output value_type          value,
   output logic               greater
);

   value_type value_ff;
   value_type value_in;
   logic      occupied;

   assign occupied = cell_index < ctrl.count;
   assign greater  = occupied && (value_ff > ctrl.key);
   assign value    = value_ff;

   // next value per broadcast operation
   always_comb begin
      value_in = value_ff;
      case (ctrl.op)
         CELL_INSERT: begin
            if (left_greater) begin
               value_in = left_value;
            end else if (greater || (cell_index == ctrl.count)) begin
               value_in = ctrl.key;
            end
         end
         CELL_SHIFT: begin
            value_in = right_value;
         end
         CELL_ROTATE: begin
            if (cell_index == ctrl.last_idx) begin
               value_in = head_value;
            end else begin
               value_in = right_value;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   // payload only, no reset needed
   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

`default_nettype wire

FILE: rtl/sorted_priority_queue.sv
// sorted priority queue: request/response channels around a chain of cells
// depends on spq_pkg, spq_if, spq_cell and sorted_priority_queue_assert.svh
//
// Requests carry an action (insert, remove smallest, display) and a value.
// Each accepted request with a defined action gives its responses on the rsp channel, in order.
// Insert and remove shift the cells in parallel; their single response is
// registered at the accept edge and is visible in the cycle after accept.
// Display walks the chain by rotating it one place per beat: a store of N
// entries gives N response beats, one per cycle while rsp_ready is high;
// the busy flag is registered at accept, the first beat is then loaded into
// the response register, and after N rotations the order is restored.
// A new request is accepted after the final display beat has been loaded.
// Throughput is one insert or remove per cycle while rsp_ready is high.
// Empty display, remove from empty and insert into a full store each give
// one error beat with item_value zero. Action code 3 is taken and dropped.
// A stalled rsp_ready holds the response register and closes req_ready.
// Synchronous reset empties the store at once; no clearing pass is needed.
`default_nettype none

module sorted_priority_queue import spq_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   spq_req_if.sink   req_bus,
   spq_rsp_if.source rsp_bus
);

`include "sorted_priority_queue_assert.svh"

   count_type     count_ff, count_in;
   count_type     remain_ff, remain_in;
   logic          disp_busy_ff, disp_busy_in;
   logic          rsp_valid_ff, rsp_valid_in;
   status_type    rsp_status_ff, rsp_status_in;
   value_type     rsp_value_ff, rsp_value_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          slot_free;
   logic          accept;
   logic          full;
   logic          empty;
   cell_ctrl_type ctrl;

   value_type cell_value   [CAPACITY];
   logic      cell_greater [CAPACITY];

   assign slot_free     = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = !disp_busy_ff && slot_free;
   assign accept        = req_bus.valid && req_bus.ready;
   assign full          = count_ff == count_type'(CAPACITY);
   assign empty         = count_ff == '0;

   // operation broadcast to the chain
   always_comb begin
      ctrl.key      = req_bus.value;
      ctrl.count    = count_ff;
      ctrl.last_idx = count_ff - count_type'(1);
      ctrl.op       = CELL_HOLD;
      if (disp_busy_ff && slot_free) begin
         ctrl.op = CELL_ROTATE;
      end else if (accept) begin
         case (req_bus.action)
            ACT_INSERT: begin
               if (!full) ctrl.op = CELL_INSERT;
            end
            ACT_REMOVE: begin
               if (!empty) ctrl.op = CELL_SHIFT;
            end
            default: begin
               ctrl.op = CELL_HOLD;
            end
         endcase
      end
   end

   // chain of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      value_type left_v;
      logic      left_g;
      value_type right_v;

      if (i == 0) begin : g_first
         assign left_v = '0;
         assign left_g = 1'b0;
      end else begin : g_inner
         assign left_v = cell_value[i-1];
         assign left_g = cell_greater[i-1];
      end

      if (i == CAPACITY - 1) begin : g_end
         assign right_v = cell_value[i];
      end else begin : g_mid
         assign right_v = cell_value[i+1];
      end

      spq_cell u_cell (
         .clock        (clock),
         .cell_index   (count_type'(i)),
         .ctrl         (ctrl),
         .left_value   (left_v),
         .left_greater (left_g),
         .right_value  (right_v),
         .head_value   (cell_value[0]),
         .value        (cell_value[i]),
         .greater      (cell_greater[i])
      );
   end

   // count, display walk and response register
   always_comb begin
      count_in      = count_ff;
      remain_in     = remain_ff;
      disp_busy_in  = disp_busy_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;

      if (disp_busy_ff && slot_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = ST_SHOWN;
         rsp_value_in  = cell_value[0];
         rsp_last_in   = remain_ff == count_type'(1);
         remain_in     = remain_ff - count_type'(1);
         disp_busy_in  = remain_ff != count_type'(1);
      end else if (accept) begin
         case (req_bus.action)
            ACT_INSERT: begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               if (full) begin
                  rsp_status_in = ST_OVERFLOW;
                  rsp_value_in  = '0;
               end else begin
                  rsp_status_in = ST_INSERTED;
                  rsp_value_in  = req_bus.value;
                  count_in      = count_ff + count_type'(1);
               end
            end
            ACT_REMOVE: begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               if (empty) begin
                  rsp_status_in = ST_UNDERFLOW;
                  rsp_value_in  = '0;
               end else begin
                  rsp_status_in = ST_REMOVED;
                  rsp_value_in  = cell_value[0];
                  count_in      = count_ff - count_type'(1);
               end
            end
            ACT_DISPLAY: begin
               if (empty) begin
                  rsp_valid_in  = 1'b1;
                  rsp_last_in   = 1'b1;
                  rsp_status_in = ST_EMPTY;
                  rsp_value_in  = '0;
               end else begin
                  disp_busy_in = 1'b1;
                  remain_in    = count_ff;
               end
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         disp_busy_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         disp_busy_ff <= disp_busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      remain_ff     <= remain_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.status     = rsp_status_ff;
   assign rsp_bus.item_value = rsp_value_ff;
   assign rsp_bus.last       = rsp_last_ff;

   // checks on the count and the display walk
   `SPQ_ASSERT_NOW(a_count_range, 1'b1, count_ff <= count_type'(CAPACITY))
   `SPQ_ASSERT_NEXT(a_insert_count, accept && (req_bus.action == ACT_INSERT) && !full,
      count_ff == $past(count_ff) + count_type'(1))
   `SPQ_ASSERT_NEXT(a_remove_count, accept && (req_bus.action == ACT_REMOVE) && !empty,
      count_ff == $past(count_ff) - count_type'(1))
   `SPQ_ASSERT_NEXT(a_display_beat, disp_busy_ff && slot_free,
      rsp_valid_ff && (rsp_status_ff == ST_SHOWN))

endmodule

`default_nettype wire
